// ----- rtl/hdlc_async_rx_deframer_unit_defines.svh -----
// Assertion macros used by the deframer RTL.
`ifndef HDLC_ASYNC_RX_DEFRAMER_UNIT_DEFINES_SVH
`define HDLC_ASYNC_RX_DEFRAMER_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define HDLCRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdlcrx: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define HDLCRX_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdlcrx: same-cycle check failed");

`endif

// ----- rtl/hdlcrx_pkg.sv -----
// Shared types, constants and CRC helper for the HDLC receive deframer.
package hdlcrx_pkg;

    // Line control bytes.
    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] ESC_BYTE  = 8'h7d;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // CRC-16/X.25 constants.
    localparam logic [15:0] CRC_INIT = 16'hffff;
    localparam logic [15:0] CRC_GOOD = 16'hf0b8;

    // Address map holds one byte per entry in a 32-bit register.
    localparam int MAX_MAP_ENTRIES = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_MAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENABLED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd3;

    // Result item kinds.
    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_BAD_CRC  = 3'd2,
        KIND_SHORT    = 3'd3,
        KIND_OVERFLOW = 3'd4
    } t_kind;

    // Result of the address-to-channel lookup.
    typedef struct packed {
        logic       hit;
        logic [1:0] idx;
    } t_chan_match;

    // One reflected CRC step over four bits. The table entry for index i
    // is i * 0x1081, whose three copies of i never overlap.
    function automatic logic [15:0] crc_nibble(input logic [15:0] c,
                                               input logic [3:0]  nib);
        logic [3:0] idx;
        idx = c[3:0] ^ nib;
        return {4'h0, c[15:4]} ^ {idx, 1'b0, idx, 3'b000, idx};
    endfunction

endpackage

// ----- rtl/hdlcrx_crc.sv -----
// Byte-wide CRC-16/X.25 update, low nibble first.
module hdlcrx_crc
    import hdlcrx_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    logic [15:0] lo_crc;

    // Two chained nibble steps cover the byte.
    assign lo_crc = crc_nibble(i_crc, i_data[3:0]);
    assign o_crc  = crc_nibble(lo_crc, i_data[7:4]);

endmodule

// ----- rtl/hdlcrx_chan_map.sv -----
// Address to channel lookup over the configured address map.
module hdlcrx_chan_map
    import hdlcrx_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic [31:0]  i_address_map,
    input  logic         i_map_enabled,
    input  logic [2:0]   i_channel_count,
    input  logic [7:0]   i_addr,
    output t_chan_match  o_match
);

    // Entries searched are limited by the channel count, the build size
    // and the four bytes of the map.
    localparam int NUM_LOOKUP =
        (NUM_CHANNELS < MAX_MAP_ENTRIES) ? NUM_CHANNELS : MAX_MAP_ENTRIES;

    // Walk from the top entry down so the lowest matching index wins.
    always_comb begin
        o_match = '0;
        if (!i_map_enabled) begin
            o_match.hit = 1'b1;
        end else begin
            for (int i = NUM_LOOKUP - 1; i >= 0; i--) begin
                if ((3'(i) < i_channel_count) && (i_address_map[8*i +: 8] == i_addr)) begin
                    o_match.hit = 1'b1;
                    o_match.idx = 2'(i);
                end
            end
        end
    end

endmodule

// ----- rtl/hdlc_async_rx_deframer_unit.sv -----
// Top level of the HDLC asynchronous receive deframer with CRC check.
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  ----------------------------------------
//  in        sink       i_in_valid/o_in_stall  i_rx_byte
//  out       source     o_out_valid/i_out_stall o_out_byte, o_channel, o_kind, o_frame_last
//  cfg       sink       i_cfg_we               i_cfg_idx, i_cfg_data
//
//  One line byte per cycle is sustained while the output is not stalled; each byte is
//  latched in an input register and then decoded into the result register.
//  The rate is set by the single pass through the byte-wide CRC and channel lookup.
//  Reset is synchronous and active low; the block hunts for a flag after reset.
//  A stall on the output holds the result register and, once the input register
//  is also full, stalls the input channel.
`include "hdlc_async_rx_deframer_unit_defines.svh"

module hdlc_async_rx_deframer_unit
    import hdlcrx_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    // Input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    // Output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic [1:0]           o_channel,
    output logic [2:0]           o_kind,
    output logic                 o_frame_last
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_ADDR = 2'd1,
        PH_CMD  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    // Configuration registers
    logic [31:0] r_address_map;
    logic        r_map_enabled;
    logic [2:0]  r_channel_count;
    logic [15:0] r_max_frame_len;

    // Input register
    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte, n_in_byte;

    // Deframer state
    t_phase      r_phase, n_phase;
    logic        r_esc, n_esc;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_older, n_older;
    logic [7:0]  r_newer, n_newer;
    logic [15:0] r_count, n_count;
    logic [1:0]  r_chan, n_chan;

    // Result register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic [1:0]  r_out_chan, n_out_chan;
    t_kind       r_out_kind, n_out_kind;
    logic        r_out_last, n_out_last;

    logic        advance;
    logic        step;
    logic        in_take;
    logic        is_esc;
    logic        is_flag;
    logic [7:0]  data_byte;
    logic [15:0] crc_seed;
    logic [15:0] crc_next;
    t_chan_match match;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_map   <= '0;
            r_map_enabled   <= 1'b0;
            r_channel_count <= 3'd1;
            r_max_frame_len <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ADDRESS_MAP:   r_address_map   <= i_cfg_data;
                CFG_MAP_ENABLED:   r_map_enabled   <= i_cfg_data[0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                CFG_MAX_FRAME_LEN: r_max_frame_len <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Handshake: a byte is decoded when latched and the result register can take it.
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Escape and flag decode of the latched byte.
    assign is_esc    = (r_in_byte == ESC_BYTE);
    assign is_flag   = (r_in_byte == FLAG_BYTE);
    assign data_byte = r_esc ? (r_in_byte ^ ESC_XOR) : r_in_byte;

    // The address byte restarts the CRC from its initial value.
    assign crc_seed = (r_phase == PH_ADDR) ? CRC_INIT : r_crc;

    hdlcrx_crc u_crc (
        .i_crc  (crc_seed),
        .i_data (data_byte),
        .o_crc  (crc_next)
    );

    // The address byte waits in the older hold slot while the command byte arrives.
    hdlcrx_chan_map #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_chan_map (
        .i_address_map   (r_address_map),
        .i_map_enabled   (r_map_enabled),
        .i_channel_count (r_channel_count),
        .i_addr          (r_older),
        .o_match         (match)
    );

    // Next-state and result logic for one byte.
    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_byte   = r_in_byte;
        n_phase     = r_phase;
        n_esc       = r_esc;
        n_crc       = r_crc;
        n_older     = r_older;
        n_newer     = r_newer;
        n_count     = r_count;
        n_chan      = r_chan;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_chan  = r_out_chan;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;

        if (in_take) begin
            n_in_valid = 1'b1;
            n_in_byte  = i_rx_byte;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end

        // A taken result empties the register unless a new one replaces it.
        if (advance) begin
            n_out_valid = 1'b0;
        end

        if (step) begin
            n_esc = is_esc;
            if (!is_esc) begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (is_flag) begin
                            n_phase = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        if (!is_flag) begin
                            n_crc   = crc_next;
                            n_older = data_byte;
                            n_phase = PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        if (is_flag) begin
                            n_phase = PH_ADDR;
                        end else begin
                            n_crc   = crc_next;
                            n_newer = data_byte;
                            if (!match.hit) begin
                                n_phase = PH_HUNT;
                            end else begin
                                n_chan  = match.idx;
                                n_count = '0;
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_out_chan = r_chan;
                        n_out_byte = '0;
                        n_out_last = 1'b1;
                        n_out_valid = 1'b1;
                        if (is_flag) begin
                            n_phase = PH_ADDR;
                            if (r_count < 16'd2) begin
                                n_out_kind = KIND_SHORT;
                            end else if (r_crc != CRC_GOOD) begin
                                n_out_kind = KIND_BAD_CRC;
                            end else begin
                                n_out_kind = KIND_GOOD;
                            end
                        end else if (r_count >= r_max_frame_len) begin
                            n_phase    = PH_HUNT;
                            n_out_kind = KIND_OVERFLOW;
                        end else begin
                            // Emit the byte from two positions back; CRC bytes stay held.
                            n_out_byte = r_older;
                            n_out_kind = KIND_DATA;
                            n_out_last = 1'b0;
                            n_count    = r_count + 16'd1;
                            n_crc      = crc_next;
                            n_older    = r_newer;
                            n_newer    = data_byte;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // State, input register and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_HUNT;
            r_esc       <= 1'b0;
            r_crc       <= '0;
            r_older     <= '0;
            r_newer     <= '0;
            r_count     <= '0;
            r_chan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_phase     <= n_phase;
            r_esc       <= n_esc;
            r_crc       <= n_crc;
            r_older     <= n_older;
            r_newer     <= n_newer;
            r_count     <= n_count;
            r_chan      <= n_chan;
            r_out_valid <= n_out_valid;
        end
        r_in_byte  <= n_in_byte;
        r_out_byte <= n_out_byte;
        r_out_chan <= n_out_chan;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_channel    = r_out_chan;
    assign o_kind       = r_out_kind;
    assign o_frame_last = r_out_last;

    // A decoded flag always cancels a pending escape.
    `HDLCRX_ASSERT_NEXT(a_flag_clears_esc, i_clk, i_rst_n, step && is_flag, !r_esc)
    // An overflow end sends the deframer back to flag hunting.
    `HDLCRX_ASSERT_NEXT(a_overflow_hunts, i_clk, i_rst_n, step && n_out_valid && (n_out_kind == KIND_OVERFLOW), r_phase == PH_HUNT)
    // End items carry a zero byte and a nonzero kind; data items are not last.
    `HDLCRX_ASSERT_SAME(a_end_item_form, i_clk, i_rst_n, r_out_valid, r_out_last == (r_out_kind != KIND_DATA) && (!r_out_last || (r_out_byte == 8'h00)))
    // A held input byte is not lost or altered while the result side is stalled.
    `HDLCRX_ASSERT_NEXT(a_in_reg_holds, i_clk, i_rst_n, o_in_stall, r_in_valid && $stable(r_in_byte))

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the HDLC asynchronous receive deframer with CRC-16/X.25 check.
module testbench;
    import hdlcrx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 64;

    // Receiver phases of the deframer.
    typedef enum logic [1:0] {
        RX_HUNT = 2'd0,
        RX_ADDR = 2'd1,
        RX_CMD  = 2'd2,
        RX_DATA = 2'd3
    } t_rx_phase;

    // Kinds of work queued for the line driver.
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_DRAIN = 2'd2
    } t_line_op;

    typedef struct {
        t_line_op             op;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
    } t_line_entry;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] channel;
        t_kind      kind;
        logic       last;
    } t_deframed;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_rx_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_out_byte;
    logic [1:0]           o_channel;
    logic [2:0]           o_kind;
    logic                 o_frame_last;

    hdlc_async_rx_deframer_unit #(
        .NUM_CHANNELS(4)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_channel   (o_channel),
        .o_kind      (o_kind),
        .o_frame_last(o_frame_last)
    );

    t_line_entry line_q[$];
    t_deframed   deframed_q[$];

    int   cycle_count = 0;
    int   error_count = 0;
    int   tail_cycles = 0;
    int   line_bytes = 0;
    logic timed_out = 1'b0;
    logic stim_done = 1'b0;
    logic in_taken = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   drain_count = 0;
    bit   quiet = 1'b0;

    // Mirror of the configuration registers.
    logic [31:0] map_word  = 32'h0;
    logic        map_on    = 1'b0;
    logic [2:0]  chan_cnt  = 3'd1;
    logic [15:0] len_limit = 16'd256;

    // Mirror of the receiver state.
    t_rx_phase   rx_phase  = RX_HUNT;
    logic        esc_armed = 1'b0;
    logic [15:0] fcs_acc   = 16'h0;
    logic [7:0]  lag_old   = 8'h0;
    logic [7:0]  lag_new   = 8'h0;
    logic [15:0] emit_cnt  = 16'h0;
    logic [1:0]  cur_chan  = 2'd0;

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Reset is held asserted and then released on a falling edge.
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Reflected CRC-16/X.25 update over one byte, least significant bit first.
    function automatic logic [15:0] fcs_step(input logic [15:0] c, input logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = (c >> 1) ^ 16'h8408;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Channel for an address, or -1 when no searched entry matches.
    function automatic int route_addr(input logic [7:0] addr);
        int n;
        if (!map_on) begin
            return 0;
        end
        n = (chan_cnt > 3'd4) ? 4 : int'(chan_cnt);
        for (int i = 0; i < n; i++) begin
            if (map_word[8*i +: 8] == addr) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Gap length for either side: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_ADDRESS_MAP:   map_word  = data;
            CFG_MAP_ENABLED:   map_on    = data[0];
            CFG_CHANNEL_COUNT: chan_cnt  = data[2:0];
            CFG_MAX_FRAME_LEN: len_limit = data[15:0];
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [7:0] b, input t_kind k);
        t_deframed item;
        item.out_byte = (k == KIND_DATA) ? b : 8'h00;
        item.channel  = cur_chan;
        item.kind     = k;
        item.last     = (k != KIND_DATA);
        deframed_q.push_back(item);
    endtask

    // Advance the receiver mirror by one line byte and queue what it yields.
    task automatic deframe_byte(input logic [7:0] raw);
        logic [7:0] d;
        logic       is_flag;
        int         ch;
        d = raw;
        is_flag = 1'b0;
        if (d == ESC_BYTE) begin
            esc_armed = 1'b1;
            return;
        end else if (d == FLAG_BYTE) begin
            is_flag = 1'b1;
            esc_armed = 1'b0;
        end else if (esc_armed) begin
            esc_armed = 1'b0;
            d = d ^ ESC_XOR;
        end
        case (rx_phase)
            RX_HUNT: begin
                if (is_flag) rx_phase = RX_ADDR;
            end
            RX_ADDR: begin
                if (!is_flag) begin
                    fcs_acc = fcs_step(16'hffff, d);
                    lag_old = d;
                    rx_phase = RX_CMD;
                end
            end
            RX_CMD: begin
                if (is_flag) begin
                    rx_phase = RX_ADDR;
                end else begin
                    fcs_acc = fcs_step(fcs_acc, d);
                    lag_new = d;
                    ch = route_addr(lag_old);
                    if (ch < 0) begin
                        rx_phase = RX_HUNT;
                    end else begin
                        cur_chan = ch[1:0];
                        emit_cnt = 16'h0;
                        rx_phase = RX_DATA;
                    end
                end
            end
            default: begin
                if (is_flag) begin
                    rx_phase = RX_ADDR;
                    if (emit_cnt < 16'd2) begin
                        push_item(8'h00, KIND_SHORT);
                    end else if (fcs_acc != 16'hf0b8) begin
                        push_item(8'h00, KIND_BAD_CRC);
                    end else begin
                        push_item(8'h00, KIND_GOOD);
                    end
                end else if (emit_cnt >= len_limit) begin
                    rx_phase = RX_HUNT;
                    push_item(8'h00, KIND_OVERFLOW);
                end else begin
                    push_item(lag_old, KIND_DATA);
                    emit_cnt = emit_cnt + 16'd1;
                    fcs_acc = fcs_step(fcs_acc, d);
                    lag_old = lag_new;
                    lag_new = d;
                end
            end
        endcase
    endtask

    // Compare one output transfer with the oldest queued item.
    task automatic check_output();
        t_deframed want;
        if (deframed_q.size() == 0) begin
            $display("%0t: unexpected output byte=%02h channel=%0d kind=%0d last=%0b",
                     $time, o_out_byte, o_channel, o_kind, o_frame_last);
            error_count++;
            return;
        end
        want = deframed_q.pop_front();
        if (o_out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, o_out_byte);
            error_count++;
        end
        if (o_channel !== want.channel) begin
            $display("%0t: channel expected %0d actual %0d", $time, want.channel, o_channel);
            error_count++;
        end
        if (o_kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, o_kind);
            error_count++;
        end
        if (o_frame_last !== want.last) begin
            $display("%0t: frame_last expected %0b actual %0b", $time, want.last, o_frame_last);
            error_count++;
        end
    endtask

    // Monitor: tracks transfers on both channels and register writes.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) timed_out <= 1'b1;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_cfg_we) load_register(i_cfg_idx, i_cfg_data);
            if (o_out_valid && !i_out_stall) check_output();
            if (i_in_valid && !o_in_stall) deframe_byte(i_rx_byte);
            if (stim_done && deframed_q.size() == 0) tail_cycles <= tail_cycles + 1;
        end
    end

    // Driver: feeds line bytes and register writes, and stalls the output side.
    always @(negedge i_clk) begin
        logic                 nxt_valid;
        logic [7:0]           nxt_byte;
        logic                 nxt_we;
        logic [CFG_IDX_W-1:0] nxt_idx;
        logic [31:0]          nxt_data;
        logic                 nxt_stall;
        nxt_valid = i_in_valid;
        nxt_byte  = i_rx_byte;
        nxt_we    = 1'b0;
        nxt_idx   = i_cfg_idx;
        nxt_data  = i_cfg_data;
        if (cycle_count % 128 == 0) quiet = ($urandom_range(0, 3) == 0);
        // Output side stall runs.
        if (stall_left > 0) begin
            nxt_stall = 1'b1;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            nxt_stall = (stall_left > 0);
            if (nxt_stall) stall_left--;
        end
        if (i_rst_n) begin
            if (in_taken) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (line_q.size() != 0) begin
                    case (line_q[0].op)
                        OP_BYTE: begin
                            nxt_valid = 1'b1;
                            nxt_byte  = line_q[0].data[7:0];
                            void'(line_q.pop_front());
                            gap_left = pick_gap();
                        end
                        OP_WRITE: begin
                            nxt_we   = 1'b1;
                            nxt_idx  = line_q[0].idx;
                            nxt_data = line_q[0].data;
                            void'(line_q.pop_front());
                        end
                        default: begin
                            // Hold off until every result is in and the pipeline is empty.
                            if (deframed_q.size() == 0) begin
                                if (drain_count >= DRAIN_CYCLES) begin
                                    void'(line_q.pop_front());
                                    drain_count = 0;
                                end else begin
                                    drain_count++;
                                end
                            end else begin
                                drain_count = 0;
                            end
                        end
                    endcase
                end
            end
            stim_done <= (line_q.size() == 0) && !nxt_valid && !nxt_we;
        end
        i_in_valid  <= nxt_valid;
        i_rx_byte   <= nxt_byte;
        i_cfg_we    <= nxt_we;
        i_cfg_idx   <= nxt_idx;
        i_cfg_data  <= nxt_data;
        i_out_stall <= nxt_stall;
    end

    task automatic push_byte(input logic [7:0] b);
        t_line_entry e;
        e.op   = OP_BYTE;
        e.idx  = '0;
        e.data = {24'h0, b};
        line_q.push_back(e);
        line_bytes++;
    endtask

    // Escape control bytes, and now and then an ordinary byte too.
    task automatic push_stuffed(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE ||
            ($urandom_range(0, 15) == 0 && b != 8'h5d && b != 8'h5e)) begin
            push_byte(ESC_BYTE);
            push_byte(b ^ ESC_XOR);
        end else begin
            push_byte(b);
        end
    endtask

    task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        t_line_entry e;
        e.op   = OP_WRITE;
        e.idx  = idx;
        e.data = data;
        line_q.push_back(e);
    endtask

    task automatic push_drain();
        t_line_entry e;
        e.op   = OP_DRAIN;
        e.idx  = '0;
        e.data = '0;
        line_q.push_back(e);
    endtask

    // Header and payload followed by the FCS, optionally with one flipped bit.
    task automatic push_frame(input logic [7:0] body[$], input bit good);
        logic [15:0] c;
        int          pos;
        c = 16'hffff;
        foreach (body[i]) c = fcs_step(c, body[i]);
        c = ~c;
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        if (!good) begin
            pos = $urandom_range(0, body.size() - 1);
            body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (body[i]) push_stuffed(body[i]);
    endtask

    task automatic push_config(input logic [31:0] map, input logic en,
                               input logic [2:0] cnt, input logic [15:0] len);
        push_drain();
        push_write(CFG_ADDRESS_MAP, map);
        push_write(CFG_MAP_ENABLED, {31'h0, en});
        push_write(CFG_CHANNEL_COUNT, {29'h0, cnt});
        push_write(CFG_MAX_FRAME_LEN, {16'h0, len});
    endtask

    // Stimulus and end of run.
    initial begin
        logic [7:0]  body[$];
        logic [31:0] gen_map;
        logic        gen_en;
        logic [2:0]  gen_cnt;
        logic [15:0] gen_len;
        int          start_bytes;
        int          r;
        int          n;

        // Good frame whose payload holds the flag value, after repeated flags.
        push_byte(FLAG_BYTE);
        push_byte(FLAG_BYTE);
        body = '{8'hff, 8'h03, 8'h7e, 8'h00};
        push_frame(body, 1'b1);
        push_byte(FLAG_BYTE);
        // Repeated escape in the payload, then an escape dropped by the closing flag.
        push_byte(8'hff); push_byte(8'h03); push_byte(ESC_BYTE); push_byte(ESC_BYTE);
        push_byte(8'h5d); push_byte(8'h41); push_byte(ESC_BYTE); push_byte(FLAG_BYTE);
        // Flag during the command byte restarts the header; then a short frame.
        push_byte(8'h00); push_byte(FLAG_BYTE); push_byte(8'h80); push_byte(8'h01);
        push_byte(FLAG_BYTE);

        // Routed channel with overflow, then an address that matches no entry.
        push_config(32'h7e1200ff, 1'b1, 3'd4, 16'd2);
        push_byte(FLAG_BYTE);
        push_byte(8'h12); push_byte(8'h03); push_byte(8'haa); push_byte(8'h55);
        push_byte(8'h0f);
        push_byte(FLAG_BYTE); push_byte(8'h33); push_byte(8'h03); push_byte(FLAG_BYTE);

        // Random phases, the first few at extreme settings.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin gen_map = $urandom; gen_en = 1'b0; gen_cnt = 3'd1; gen_len = 16'hffff; end
                1: begin gen_map = $urandom; gen_en = 1'b1; gen_cnt = 3'd4; gen_len = 16'd0; end
                2: begin gen_map = $urandom; gen_en = 1'b1; gen_cnt = 3'd0; gen_len = 16'd256; end
                3: begin gen_map = 32'hffffffff; gen_en = 1'b1; gen_cnt = 3'd7; gen_len = 16'd1; end
                4: begin gen_map = 32'h0; gen_en = 1'b1; gen_cnt = 3'd3; gen_len = 16'd2; end
                default: begin
                    gen_map = $urandom;
                    gen_en  = 1'($urandom_range(0, 1));
                    gen_cnt = 3'($urandom_range(0, 7));
                    gen_len = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                              16'($urandom_range(2, 30));
                end
            endcase
            push_config(gen_map, gen_en, gen_cnt, gen_len);
            start_bytes = line_bytes;
            while (line_bytes - start_bytes < 55) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    // Well-formed frame, mostly to an address in the table.
                    push_byte(FLAG_BYTE);
                    if ($urandom_range(0, 4) == 0) push_byte(FLAG_BYTE);
                    body.delete();
                    if (gen_en && $urandom_range(0, 4) != 0) begin
                        body.push_back(gen_map[8*$urandom_range(0, 3) +: 8]);
                    end else begin
                        body.push_back(8'($urandom));
                    end
                    body.push_back(8'($urandom));
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) :
                        $urandom_range(0, 6);
                    repeat (n) body.push_back(8'($urandom));
                    push_frame(body, $urandom_range(0, 4) != 0);
                    push_byte(FLAG_BYTE);
                end else if (r < 85) begin
                    // Line noise leaning on the control bytes.
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            push_byte($urandom_range(0, 1) ? ESC_BYTE : FLAG_BYTE);
                        end else begin
                            push_byte(8'($urandom));
                        end
                    end
                end else begin
                    // Frame cut short; the next flag closes it.
                    push_byte(FLAG_BYTE);
                    push_stuffed(gen_map[8*$urandom_range(0, 3) +: 8]);
                    repeat ($urandom_range(0, 4)) push_stuffed(8'($urandom));
                end
            end
        end

        wait (tail_cycles >= TAIL_CYCLES || timed_out);
        // A result still waiting at the end was never expected.
        if (!timed_out && o_out_valid) begin
            $display("%0t: output valid expected 0 actual %0b", $time, o_out_valid);
            error_count++;
        end
        if (timed_out) begin
            $display("testbench: errors");
        end else if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
